### rtl/yuyv_to_rgb_10bit_packer_assert.svh
// Assertion macros for the YUYV to RGB packer, used by the merge stage.
`ifndef YUYV_TO_RGB_10BIT_PACKER_ASSERT_SVH
`define YUYV_TO_RGB_10BIT_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define YRGB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define YRGB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/yrgb_pkg.sv
// Types and constants for the YUYV to RGB 2:10:10:10 packer.
`default_nettype none

package yrgb_pkg;

    // Widths of the beat fields
    localparam int BYTE_W  = 8;
    localparam int CHAN_W  = 10;
    localparam int PIXEL_W = 32;
    localparam int IN_W    = 4 * BYTE_W;
    localparam int OUT_W   = 2 * PIXEL_W;

    // Signed width that holds every product and every sum
    localparam int SUM_W   = 25;
    localparam int FRAC_W  = 10;
    localparam int DIFF_W  = BYTE_W + 1;

    // Offsets of luma and chroma
    localparam logic signed [DIFF_W-1:0] LUMA_OFS   = DIFF_W'(16);
    localparam logic signed [DIFF_W-1:0] CHROMA_OFS = DIFF_W'(128);

    // Conversion coefficients (Q10)
    localparam logic signed [SUM_W-1:0] K_R_Y = SUM_W'(4778);
    localparam logic signed [SUM_W-1:0] K_R_U = SUM_W'(2);
    localparam logic signed [SUM_W-1:0] K_R_V = SUM_W'(6931);
    localparam logic signed [SUM_W-1:0] K_G_Y = SUM_W'(4826);
    localparam logic signed [SUM_W-1:0] K_G_U = SUM_W'(775);
    localparam logic signed [SUM_W-1:0] K_G_V = SUM_W'(2670);
    localparam logic signed [SUM_W-1:0] K_B_Y = SUM_W'(4768);
    localparam logic signed [SUM_W-1:0] K_B_U = SUM_W'(8809);
    localparam logic signed [SUM_W-1:0] K_B_V = SUM_W'(11);

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
    localparam logic [1:0]        ALPHA    = 2'b11;

    typedef logic [CHAN_W-1:0] chan_t;

    // One converted pixel, red in the low bits
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } rgb_t;

    // Pipeline load enables from the merge stage to the lanes
    typedef struct packed {
        logic ld_prod;
        logic ld_chan;
    } lane_ctrl_t;

    // Floor-shift a Q10 sum and clamp it to the channel range
    function automatic chan_t clamp_chan(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] q;
        begin
            q = sum >>> FRAC_W;
            if (sum < 0) begin
                clamp_chan = '0;
            end else if (q > $signed({{(SUM_W-CHAN_W){1'b0}}, CHAN_MAX})) begin
                clamp_chan = CHAN_MAX;
            end else begin
                clamp_chan = q[CHAN_W-1:0];
            end
        end
    endfunction

    // Pack one pixel word: alpha, red, green, blue from the low bit up
    function automatic logic [PIXEL_W-1:0] pack_pixel(input rgb_t px);
        pack_pixel = {px.blue, px.green, px.red, ALPHA};
    endfunction

endpackage

`default_nettype wire

### rtl/yrgb_lane.sv
// One conversion lane: luma plus shared chroma to one clamped RGB pixel.
`default_nettype none

module yrgb_lane (
    input  wire logic                          aclk,
    input  wire yrgb_pkg::lane_ctrl_t          ctrl,
    input  wire logic [yrgb_pkg::BYTE_W-1:0]   luma,
    input  wire logic [yrgb_pkg::BYTE_W-1:0]   chroma_blue,
    input  wire logic [yrgb_pkg::BYTE_W-1:0]   chroma_red,
    output yrgb_pkg::rgb_t                     pixel
);
    import yrgb_pkg::*;

    logic signed [DIFF_W-1:0] y_diff;
    logic signed [DIFF_W-1:0] u_diff;
    logic signed [DIFF_W-1:0] v_diff;
    logic signed [SUM_W-1:0]  y_ext;
    logic signed [SUM_W-1:0]  u_ext;
    logic signed [SUM_W-1:0]  v_ext;

    logic signed [SUM_W-1:0]  r_y_reg, r_u_reg, r_v_reg;
    logic signed [SUM_W-1:0]  g_y_reg, g_u_reg, g_v_reg;
    logic signed [SUM_W-1:0]  b_y_reg, b_u_reg, b_v_reg;
    logic signed [SUM_W-1:0]  r_sum, g_sum, b_sum;
    rgb_t                     pixel_reg;
    rgb_t                     pixel_next;

    // Remove the luma and chroma offsets
    assign y_diff = $signed({1'b0, luma}) - LUMA_OFS;
    assign u_diff = $signed({1'b0, chroma_blue}) - CHROMA_OFS;
    assign v_diff = $signed({1'b0, chroma_red}) - CHROMA_OFS;
    assign y_ext  = SUM_W'(y_diff);
    assign u_ext  = SUM_W'(u_diff);
    assign v_ext  = SUM_W'(v_diff);

    // Stage one: register the coefficient products
    always_ff @(posedge aclk) begin
        if (ctrl.ld_prod) begin
            r_y_reg <= y_ext * K_R_Y;
            r_u_reg <= u_ext * K_R_U;
            r_v_reg <= v_ext * K_R_V;
            g_y_reg <= y_ext * K_G_Y;
            g_u_reg <= u_ext * K_G_U;
            g_v_reg <= v_ext * K_G_V;
            b_y_reg <= y_ext * K_B_Y;
            b_u_reg <= u_ext * K_B_U;
            b_v_reg <= v_ext * K_B_V;
        end
    end

    // Stage two: sum, floor-shift and clamp each channel
    assign r_sum = r_y_reg + r_u_reg + r_v_reg;
    assign g_sum = g_y_reg - g_u_reg - g_v_reg;
    assign b_sum = b_y_reg + b_u_reg + b_v_reg;

    always_comb begin
        pixel_next.red   = clamp_chan(r_sum);
        pixel_next.green = clamp_chan(g_sum);
        pixel_next.blue  = clamp_chan(b_sum);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld_chan) begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

### rtl/yrgb_merge.sv
// Merge stage: pipeline flow control and packing of both lanes into one beat.
`default_nettype none

`include "yuyv_to_rgb_10bit_packer_assert.svh"

module yrgb_merge (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // Fields from bit 0: pixel_first[31:0], pixel_second[63:32]
    output logic [yrgb_pkg::OUT_W-1:0]        m_tdata,
    input  wire yrgb_pkg::rgb_t               pixel_first,
    input  wire yrgb_pkg::rgb_t               pixel_second,
    output yrgb_pkg::lane_ctrl_t              ctrl
);
    import yrgb_pkg::*;

    logic prod_vld_reg, prod_vld_next;
    logic chan_vld_reg, chan_vld_next;
    logic chan_rdy;
    logic prod_rdy;

    // Each stage moves when it is empty or the stage after it takes
    assign chan_rdy = !chan_vld_reg || m_tready;
    assign prod_rdy = !prod_vld_reg || chan_rdy;

    assign ctrl.ld_prod = prod_rdy;
    assign ctrl.ld_chan = chan_rdy;

    always_comb begin
        prod_vld_next = prod_vld_reg;
        chan_vld_next = chan_vld_reg;
        if (prod_rdy) begin
            prod_vld_next = s_tvalid;
        end
        if (chan_rdy) begin
            chan_vld_next = prod_vld_reg;
        end
    end

    // Advance the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            chan_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= prod_vld_next;
            chan_vld_reg <= chan_vld_next;
        end
    end

    // Pack both pixels into the result beat
    assign s_tready = prod_rdy;
    assign m_tvalid = chan_vld_reg;
    assign m_tdata  = {pack_pixel(pixel_second), pack_pixel(pixel_first)};

    `YRGB_ASSERT_NEXT(a_accept_fills, aclk, aresetn, s_tvalid && s_tready, prod_vld_reg, "accepted beat not held in product stage")
    `YRGB_ASSERT_NEXT(a_stage_moves, aclk, aresetn, prod_vld_reg && chan_rdy, chan_vld_reg, "product stage did not advance")
    `YRGB_ASSERT_NOW(a_full_blocks, aclk, aresetn, prod_vld_reg && chan_vld_reg && !m_tready, !s_tready, "input taken while pipeline full and stalled")
    `YRGB_ASSERT_NOW(a_alpha_set, aclk, aresetn, m_tvalid, (m_tdata[1:0] == ALPHA) && (m_tdata[PIXEL_W+1:PIXEL_W] == ALPHA), "alpha bits not set")

endmodule

`default_nettype wire

### rtl/yuyv_to_rgb_10bit_packer.sv
// Top level: YUYV macropixel in, two packed 2:10:10:10 RGB pixels out.
// An accepted input beat passes the product registers, then the channel registers, to its result beat.
// Throughput: one macropixel per cycle while m_tready is high, set by the two-stage multiply/clamp lanes.
// s_tready follows m_tready through the two stage valid flags; a stall empties
// no stage, and an empty stage takes a beat even while the output waits.
// Reset (aresetn low, synchronous) clears both stage valid flags; data is not reset.
`default_nettype none

module yuyv_to_rgb_10bit_packer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: luma_first[7:0], chroma_blue[15:8],
    // luma_second[23:16], chroma_red[31:24]
    input  wire logic [yrgb_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // Fields from bit 0: pixel_first[31:0], pixel_second[63:32]
    output logic [yrgb_pkg::OUT_W-1:0]       m_tdata
);
    import yrgb_pkg::*;

    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] chroma_blue;
    logic [BYTE_W-1:0] luma_second;
    logic [BYTE_W-1:0] chroma_red;
    lane_ctrl_t        ctrl;
    rgb_t              pixel_first;
    rgb_t              pixel_second;

    // Split the input beat
    assign luma_first  = s_tdata[BYTE_W-1:0];
    assign chroma_blue = s_tdata[2*BYTE_W-1:BYTE_W];
    assign luma_second = s_tdata[3*BYTE_W-1:2*BYTE_W];
    assign chroma_red  = s_tdata[4*BYTE_W-1:3*BYTE_W];

    // One lane per pixel of the pair, sharing the chroma
    yrgb_lane u_lane_first (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .luma        (luma_first),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .pixel       (pixel_first)
    );

    yrgb_lane u_lane_second (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .luma        (luma_second),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .pixel       (pixel_second)
    );

    yrgb_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .ctrl         (ctrl)
    );

endmodule

`default_nettype wire

### tb/yuyv_to_rgb_10bit_packer_checker.sv
// Checker for the YUYV to RGB packer: predicts each pixel pair and compares result beats.
`timescale 1ns / 1ps

module yuyv_to_rgb_10bit_packer_checker (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    input  wire logic                        s_tready,
    // Fields from bit 0: luma_first, chroma_blue, luma_second, chroma_red
    input  wire logic [yrgb_pkg::IN_W-1:0]   s_tdata,
    input  wire logic                        m_tvalid,
    input  wire logic                        m_tready,
    // Fields from bit 0: pixel_first, pixel_second
    input  wire logic [yrgb_pkg::OUT_W-1:0]  m_tdata,
    output int                               mismatch_total,
    output int                               pairs_outstanding
);

    // Q10 conversion coefficients per channel and component
    localparam int RED_Y   = 4778;
    localparam int RED_U   = 2;
    localparam int RED_V   = 6931;
    localparam int GREEN_Y = 4826;
    localparam int GREEN_U = -775;
    localparam int GREEN_V = -2670;
    localparam int BLUE_Y  = 4768;
    localparam int BLUE_U  = 8809;
    localparam int BLUE_V  = 11;
    localparam int LUMA_BLACK   = 16;
    localparam int CHROMA_ZERO  = 128;
    localparam int CHAN_TOP     = 1023;
    localparam int REPORT_LIMIT = 10;
    localparam logic [1:0] OPAQUE = 2'b11;

    typedef struct packed {
        logic [31:0] second;
        logic [31:0] first;
    } pixel_pair_t;

    pixel_pair_t expected_pairs[$];

    // Floor the Q10 sum and clamp it into one 10-bit channel
    function automatic logic [9:0] clamp_q10(input int sum);
        int q;
        q = sum >>> 10;
        if (sum < 0) return '0;
        if (q > CHAN_TOP) return 10'(CHAN_TOP);
        return q[9:0];
    endfunction

    // Convert one luma sample with the shared chroma into a 2:10:10:10 word
    function automatic logic [31:0] rgb_word(input logic [7:0] luma, input int u, input int v);
        int y;
        logic [9:0] red;
        logic [9:0] green;
        logic [9:0] blue;
        y     = int'(luma) - LUMA_BLACK;
        red   = clamp_q10(RED_Y * y + RED_U * u + RED_V * v);
        green = clamp_q10(GREEN_Y * y + GREEN_U * u + GREEN_V * v);
        blue  = clamp_q10(BLUE_Y * y + BLUE_U * u + BLUE_V * v);
        return {blue, green, red, OPAQUE};
    endfunction

    function automatic pixel_pair_t macropixel_to_rgb(input logic [31:0] yuyv);
        pixel_pair_t pair;
        int u;
        int v;
        u = int'(yuyv[15:8]) - CHROMA_ZERO;
        v = int'(yuyv[31:24]) - CHROMA_ZERO;
        pair.first  = rgb_word(yuyv[7:0], u, v);
        pair.second = rgb_word(yuyv[23:16], u, v);
        return pair;
    endfunction

    initial begin
        mismatch_total    = 0;
        pairs_outstanding = 0;
    end

    always @(posedge aclk) begin
        pixel_pair_t want;
        pixel_pair_t got;
        if (aresetn) begin
            // Check a result beat against the oldest prediction first
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pairs.size() == 0) begin
                    mismatch_total <= mismatch_total + 1;
                    if (mismatch_total < REPORT_LIMIT)
                        $display("%0t: result beat with nothing expected: first %h second %h",
                                 $time, got.first, got.second);
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.first !== want.first || got.second !== want.second) begin
                        mismatch_total <= mismatch_total + 1;
                        if (mismatch_total < REPORT_LIMIT)
                            $display("%0t: mismatch: first exp %h got %h, second exp %h got %h",
                                     $time, want.first, got.first, want.second, got.second);
                    end
                end
            end
            // Predict the pair for each accepted macropixel beat
            if (s_tvalid && s_tready)
                expected_pairs.push_back(macropixel_to_rgb(s_tdata));
            pairs_outstanding <= expected_pairs.size();
        end
    end

endmodule

### tb/yuyv_to_rgb_10bit_packer_tb.sv
// Testbench top for the YUYV to RGB packer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module yuyv_to_rgb_10bit_packer_tb;

    localparam int RANDOM_BEATS  = 1350;
    localparam int HANG_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 4;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    // Fields from bit 0: luma_first, chroma_blue, luma_second, chroma_red
    logic [yrgb_pkg::IN_W-1:0]   s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    // Fields from bit 0: pixel_first, pixel_second
    logic [yrgb_pkg::OUT_W-1:0]  m_tdata;

    int mismatch_total;
    int pairs_outstanding;
    int quiet_cycles;
    bit src_gaps_on;
    bit sink_stalls_on;

    yuyv_to_rgb_10bit_packer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    yuyv_to_rgb_10bit_packer_checker pixel_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatch_total    (mismatch_total),
        .pairs_outstanding (pairs_outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Abort when no beat moves on either channel for too long
    initial quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("yuyv_to_rgb_10bit_packer_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stall the result channel in random bursts
    initial begin
        m_tready = 1'b0;
        forever begin
            if (sink_stalls_on && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    end

    // Byte with a bias toward the range ends and the offset points
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [12] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127,
                                     8'd128, 8'd129, 8'd235, 8'd240, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0)
            return corners[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    // Present one macropixel beat and hold it until accepted
    task automatic send_macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                   input logic [7:0] y1, input logic [7:0] cr);
        s_tdata  <= {cr, y1, cb, y0};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        // Drop valid for a random gap
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: black, white, offsets, clamping at both ends, bit patterns
        send_macropixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_macropixel(8'd16,  8'd128, 8'd235, 8'd128);
        send_macropixel(8'd0,   8'd128, 8'd15,  8'd128);
        send_macropixel(8'd255, 8'd128, 8'd254, 8'd128);
        send_macropixel(8'd255, 8'd255, 8'd128, 8'd128);
        send_macropixel(8'd128, 8'd128, 8'd255, 8'd255);
        send_macropixel(8'd16,  8'd255, 8'd16,  8'd255);
        send_macropixel(8'd16,  8'd0,   8'd16,  8'd0);
        send_macropixel(8'd235, 8'd0,   8'd235, 8'd0);
        send_macropixel(8'd0,   8'd255, 8'd255, 8'd0);
        send_macropixel(8'd255, 8'd0,   8'd0,   8'd255);
        send_macropixel(8'd17,  8'd129, 8'd17,  8'd127);
        send_macropixel(8'hAA,  8'h55,  8'hAA,  8'h55);
        send_macropixel(8'h55,  8'hAA,  8'h55,  8'hAA);
        send_macropixel(8'd81,  8'd90,  8'd145, 8'd240);
        send_macropixel(8'd41,  8'd240, 8'd210, 8'd110);

        // Random: gaps and stalls, then stalls only, then both again, then neither
        for (int phase = 0; phase < 4; phase++) begin
            src_gaps_on    = (phase == 0 || phase == 2);
            sink_stalls_on = (phase == 0 || phase == 2);
            if (phase == 1) sink_stalls_on = 1'b1;
            for (int n = 0; n < RANDOM_BEATS / 4; n++)
                send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then give the verdict
        while (pairs_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_total == 0 && pairs_outstanding == 0)
            $display("yuyv_to_rgb_10bit_packer_tb: done, clean");
        else
            $display("yuyv_to_rgb_10bit_packer_tb: done, errors");
        $finish;
    end

endmodule
